>>> design/fpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpl_pkg;

    localparam int unsigned MAX_REPLY_BYTES = 32;
    localparam int unsigned DLEN_W          = $clog2(MAX_REPLY_BYTES + 1);

    localparam logic [7:0] SYNC_HI     = 8'hEF;
    localparam logic [7:0] SYNC_LO     = 8'h01;
    localparam logic [7:0] PID_COMMAND = 8'h01;
    localparam logic [7:0] CODE_NOREPLY = 8'hFF;
    localparam logic [7:0] CODE_BADHDR  = 8'hFE;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [31:0] ADDR_RESET    = 32'hFFFF_FFFF;
    localparam logic [3:0]  HDR_BYTES     = 4'd9;

    // word positions inside an outgoing command frame and inside a reply job
    localparam logic [3:0] IDX_FIRST  = 4'd0;
    localparam logic [3:0] IDX_CMD    = 4'd9;
    localparam logic [3:0] IDX_SUM_LO = 4'd11;
    localparam logic [3:0] IDX_DATA   = 4'd0;
    localparam logic [3:0] IDX_DONE   = 4'd1;

    typedef enum logic [0:0] {
        CFG_BYTE_TIMEOUT = 1'b0,
        CFG_DEVICE_ADDR  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_PARAM = 2'd1,
        REQ_RX    = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOREPLY = 2'd1,
        ST_BADHDR  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PARAMS  = 3'd1,
        PH_HEADER  = 3'd2,
        PH_CONFIRM = 3'd3,
        PH_BODY    = 3'd4
    } phase_t;

    typedef enum logic [0:0] {
        JOB_FRAME = 1'b0,
        JOB_REPLY = 1'b1
    } job_kind_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] in_byte;
        logic [7:0] param_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // one queued unit of work for the back end
    typedef struct packed {
        job_kind_t   kind;
        logic [3:0]  first_idx;
        logic        chk;       // frame: append checksum
        logic        done_en;   // reply: emit done word
        logic [7:0]  data;
        logic [7:0]  code;
        logic [1:0]  status;
        logic [8:0]  plen;
        logic [15:0] sum;
    } job_t;

endpackage

`default_nettype wire

>>> design/fpl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fpl_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fpl_pkg::in_item_t s_item,
    input  wire logic [15:0]      byte_timeout,
    input  wire logic             q_full,
    output logic                  push,
    output fpl_pkg::job_t         push_job
);
    import fpl_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  params_left_reg, params_left_next;
    logic [15:0] reply_length_reg, reply_length_next;
    logic [7:0]  confirm_reg, confirm_next;
    logic        header_ok_reg, header_ok_next;
    logic [15:0] wait_reg, wait_next;

    logic              accept;
    logic [1:0]        req;
    logic [7:0]        b;
    logic [7:0]        cnt;
    logic [8:0]        plen;
    logic [15:0]       start_sum;
    logic [15:0]       param_sum;
    logic [7:0]        params_dec;
    logic [15:0]       bc_inc;
    logic [15:0]       wait_inc;
    logic              timed_out;
    logic              hdr_ok_now;
    logic              hdr_end;
    logic [15:0]       rl_minus3;
    logic [DLEN_W-1:0] data_limit;
    logic              in_data;
    logic              body_end;
    logic              confirm_short;
    logic              awaiting;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign req     = s_item.req_type;
    assign b       = s_item.in_byte;
    assign cnt     = s_item.param_count;

    assign plen       = {1'b0, cnt} + 9'd3;
    assign start_sum  = 16'd1 + {15'd0, plen[8]} + {8'd0, plen[7:0]} + {8'd0, b};
    assign param_sum  = sum_reg + {8'd0, b};
    assign params_dec = params_left_reg - 8'd1;
    assign bc_inc     = byte_count_reg + 16'd1;
    assign wait_inc   = wait_reg + 16'd1;
    assign timed_out  = (wait_inc == 16'd0) || (wait_inc >= byte_timeout);
    assign awaiting   = phase_reg inside {PH_HEADER, PH_CONFIRM, PH_BODY};

    assign hdr_ok_now = header_ok_reg
                      && !((byte_count_reg == 16'd0) && (b != SYNC_HI))
                      && !((byte_count_reg == 16'd1) && (b != SYNC_LO));
    assign hdr_end    = bc_inc >= {12'd0, HDR_BYTES};

    // data bytes passed on: length-3 clamped, none when length is below three
    assign rl_minus3 = reply_length_reg - 16'd3;
    always_comb begin
        if (reply_length_reg < 16'd3) begin
            data_limit = '0;
        end else if (rl_minus3 > 16'(MAX_REPLY_BYTES)) begin
            data_limit = DLEN_W'(MAX_REPLY_BYTES);
        end else begin
            data_limit = rl_minus3[DLEN_W-1:0];
        end
    end

    assign in_data       = byte_count_reg < {{(16 - DLEN_W){1'b0}}, data_limit};
    assign body_end      = bc_inc >= (reply_length_reg - 16'd1);
    assign confirm_short = reply_length_reg <= 16'd1;

    // next state
    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        sum_next          = sum_reg;
        params_left_next  = params_left_reg;
        reply_length_next = reply_length_reg;
        confirm_next      = confirm_reg;
        header_ok_next    = header_ok_reg;
        wait_next         = wait_reg;
        if (accept) begin
            case (req)
                REQ_START: begin
                    sum_next          = start_sum;
                    params_left_next  = cnt;
                    reply_length_next = '0;
                    confirm_next      = '0;
                    byte_count_next   = '0;
                    wait_next         = '0;
                    header_ok_next    = 1'b1;
                    phase_next        = (cnt == 8'd0) ? PH_HEADER : PH_PARAMS;
                end
                REQ_PARAM: begin
                    if (phase_reg == PH_PARAMS) begin
                        sum_next         = param_sum;
                        params_left_next = params_dec;
                        if (params_dec == 8'd0) begin
                            phase_next      = PH_HEADER;
                            byte_count_next = '0;
                            wait_next       = '0;
                            header_ok_next  = 1'b1;
                        end
                    end
                end
                REQ_RX: begin
                    case (phase_reg)
                        PH_HEADER: begin
                            wait_next       = '0;
                            header_ok_next  = hdr_ok_now;
                            byte_count_next = bc_inc;
                            if (byte_count_reg == 16'd7) begin
                                reply_length_next = {b, reply_length_reg[7:0]};
                            end
                            if (byte_count_reg == 16'd8) begin
                                reply_length_next = {reply_length_reg[15:8], b};
                            end
                            if (hdr_end) begin
                                byte_count_next = '0;
                                phase_next      = hdr_ok_now ? PH_CONFIRM : PH_IDLE;
                            end
                        end
                        PH_CONFIRM: begin
                            wait_next       = '0;
                            confirm_next    = b;
                            byte_count_next = '0;
                            phase_next      = confirm_short ? PH_IDLE : PH_BODY;
                        end
                        PH_BODY: begin
                            wait_next       = '0;
                            byte_count_next = bc_inc;
                            if (body_end) begin
                                phase_next      = PH_IDLE;
                                byte_count_next = '0;
                            end
                        end
                        default: begin
                            // receiver flushed outside a reply
                        end
                    endcase
                end
                REQ_TICK: begin
                    if (awaiting) begin
                        wait_next = wait_inc;
                        if (timed_out) begin
                            phase_next      = PH_IDLE;
                            byte_count_next = '0;
                            wait_next       = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // work handed to the back end
    always_comb begin
        push     = 1'b0;
        push_job = '0;
        if (accept) begin
            case (req)
                REQ_START: begin
                    push               = 1'b1;
                    push_job.kind      = JOB_FRAME;
                    push_job.first_idx = IDX_FIRST;
                    push_job.chk       = (cnt == 8'd0);
                    push_job.data      = b;
                    push_job.plen      = plen;
                    push_job.sum       = start_sum;
                end
                REQ_PARAM: begin
                    if (phase_reg == PH_PARAMS) begin
                        push               = 1'b1;
                        push_job.kind      = JOB_FRAME;
                        push_job.first_idx = IDX_CMD;
                        push_job.chk       = (params_dec == 8'd0);
                        push_job.data      = b;
                        push_job.sum       = param_sum;
                    end
                end
                REQ_RX: begin
                    push_job.kind      = JOB_REPLY;
                    push_job.first_idx = IDX_DONE;
                    push_job.done_en   = 1'b1;
                    push_job.data      = b;
                    push_job.status    = ST_OK;
                    case (phase_reg)
                        PH_HEADER: begin
                            push            = hdr_end && !hdr_ok_now;
                            push_job.code   = CODE_BADHDR;
                            push_job.status = ST_BADHDR;
                        end
                        PH_CONFIRM: begin
                            push          = confirm_short;
                            push_job.code = b;
                        end
                        PH_BODY: begin
                            push               = in_data || body_end;
                            push_job.first_idx = in_data ? IDX_DATA : IDX_DONE;
                            push_job.done_en   = body_end;
                            push_job.code      = confirm_reg;
                        end
                        default: begin
                        end
                    endcase
                end
                REQ_TICK: begin
                    push               = awaiting && timed_out;
                    push_job.kind      = JOB_REPLY;
                    push_job.first_idx = IDX_DONE;
                    push_job.done_en   = 1'b1;
                    if (phase_reg == PH_BODY) begin
                        push_job.code   = confirm_reg;
                        push_job.status = ST_OK;
                    end else begin
                        push_job.code   = CODE_NOREPLY;
                        push_job.status = ST_NOREPLY;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            byte_count_reg   <= '0;
            sum_reg          <= '0;
            params_left_reg  <= '0;
            reply_length_reg <= '0;
            confirm_reg      <= '0;
            header_ok_reg    <= 1'b1;
            wait_reg         <= '0;
        end else begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            sum_reg          <= sum_next;
            params_left_reg  <= params_left_next;
            reply_length_reg <= reply_length_next;
            confirm_reg      <= confirm_next;
            header_ok_reg    <= header_ok_next;
            wait_reg         <= wait_next;
        end
    end

endmodule

`default_nettype wire

>>> design/fpl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fpl_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire fpl_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output fpl_pkg::job_t      q_job
);
    import fpl_pkg::*;

    job_t       entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("queue count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("queue written while full");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> q_valid)
        else $error("queue read while empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && count_reg == 2'd1) |=> full)
        else $error("queue failed to fill");

endmodule

`default_nettype wire

>>> design/fpl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fpl_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire fpl_pkg::job_t q_job,
    output logic               pop,
    input  wire logic [31:0]   device_address,
    output logic               m_valid,
    input  wire logic          m_ready,
    output fpl_pkg::out_item_t m_item
);
    import fpl_pkg::*;

    job_t      cur_reg, cur_next;
    logic      cur_valid_reg, cur_valid_next;
    logic [3:0] idx_reg, idx_next;
    out_item_t m_item_reg, m_item_next;
    logic      m_valid_reg, m_valid_next;

    out_item_t word;
    logic      out_free;
    logic      advance;
    logic      cur_done;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = cur_valid_reg && out_free;

    // word at the current position of the job
    always_comb begin
        word          = '0;
        word.out_kind = KIND_TX;
        word.status   = ST_OK;
        if (cur_reg.kind == JOB_FRAME) begin
            case (idx_reg)
                4'd0:    word.out_byte = SYNC_HI;
                4'd1:    word.out_byte = SYNC_LO;
                4'd2:    word.out_byte = device_address[31:24];
                4'd3:    word.out_byte = device_address[23:16];
                4'd4:    word.out_byte = device_address[15:8];
                4'd5:    word.out_byte = device_address[7:0];
                4'd6:    word.out_byte = PID_COMMAND;
                4'd7:    word.out_byte = {7'd0, cur_reg.plen[8]};
                4'd8:    word.out_byte = cur_reg.plen[7:0];
                4'd9:    word.out_byte = cur_reg.data;
                4'd10:   word.out_byte = cur_reg.sum[15:8];
                4'd11:   word.out_byte = cur_reg.sum[7:0];
                default: word.out_byte = '0;
            endcase
            word.last = (idx_reg == IDX_SUM_LO) || (idx_reg == IDX_CMD && !cur_reg.chk);
        end else begin
            if (idx_reg == IDX_DATA) begin
                word.out_kind = KIND_DATA;
                word.out_byte = cur_reg.data;
                word.last     = !cur_reg.done_en;
            end else begin
                word.out_kind = KIND_DONE;
                word.out_byte = cur_reg.code;
                word.status   = cur_reg.status;
                word.last     = 1'b1;
            end
        end
    end

    assign cur_done = !cur_valid_reg || (advance && word.last);
    assign pop      = cur_done && q_valid;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_next       = q_job;
            cur_valid_next = 1'b1;
            idx_next       = q_job.first_idx;
        end else if (cur_done) begin
            cur_valid_next = 1'b0;
        end else if (advance) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    // output register holds a word until m_ready takes it; the job stalls while it waits
    always_comb begin
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_item_next  = word;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_item_reg <= m_item_next;
    end

endmodule

`default_nettype wire

>>> design/fingerprint_packet_link.sv
// Command/response framer for a serial fingerprint sensor module.
// s_ channel (valid/ready) carries one word per request: start command, parameter
// byte, received byte or one-millisecond tick. m_ channel (valid/ready) carries the
// results: bytes to transmit, reply data bytes and a done word with status.
// cfg_ channel writes the per-byte timeout (index 0) and device address (index 1);
// it is always ready; writing it only while the link is quiet is left to the user.
// A front end updates the link state in the cycle a word is accepted and queues
// the work; a two-entry queue feeds a back end that emits one result per cycle
// into an output register while m_ready does not stall it.
// The first result of a word passes the queue entry, the back end's current-job
// register and the output register. A start gives 10 or 12 result words, a
// parameter byte 1 or 3, and a received byte or tick at most 2.
// Requests that give no result (most ticks and received bytes) queue nothing.
// When m_ready is low the output register holds, the queue fills and s_ready
// drops after two queued jobs. Reset clears the link to idle, the timeout to
// 500 ms and the address to all ones, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module fingerprint_packet_link (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fpl_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fpl_pkg::out_item_t      m_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import fpl_pkg::*;

    logic [15:0] timeout_reg;
    logic [31:0] address_reg;

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic q_valid;
    job_t q_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            address_reg <= ADDR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BYTE_TIMEOUT: timeout_reg <= cfg_data[15:0];
                CFG_DEVICE_ADDR:  address_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    fpl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .byte_timeout (timeout_reg),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job)
    );

    fpl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    fpl_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_job          (q_job),
        .pop            (pop),
        .device_address (address_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item)
    );

endmodule

`default_nettype wire

>>> dv/fpl_link_checker.sv
`timescale 1ns / 1ps

module fpl_link_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire fpl_pkg::in_item_t  s_item,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire fpl_pkg::out_item_t m_item,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      err_count,
    output int                      words_due
);
    import fpl_pkg::*;

    logic [15:0] tmo_ticks;
    logic [31:0] dev_addr;

    phase_t      link_phase;
    logic [15:0] rx_count;
    logic [15:0] frame_sum;
    logic [7:0]  params_due;
    logic [15:0] resp_len;
    logic [7:0]  confirm;
    logic        hdr_good;
    logic [15:0] idle_ms;

    out_item_t step_words[$];
    out_item_t expected_words[$];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        $display("%0t: %s mismatch, got %02h expected %02h", $time, what, got, want);
    endtask

    function automatic out_item_t make_word(input out_kind_t k, input logic [7:0] b,
                                            input status_t st);
        out_item_t w;
        w.out_kind = k;
        w.out_byte = b;
        w.status   = st;
        w.last     = 1'b0;
        return w;
    endfunction

    // checksum goes out and the link starts listening for the reply header
    task automatic close_frame();
        step_words.push_back(make_word(KIND_TX, frame_sum[15:8], ST_OK));
        step_words.push_back(make_word(KIND_TX, frame_sum[7:0], ST_OK));
        link_phase = PH_HEADER;
        rx_count   = 16'd0;
        idle_ms    = 16'd0;
        hdr_good   = 1'b1;
    endtask

    task automatic end_exchange(input logic [7:0] code, input status_t st);
        step_words.push_back(make_word(KIND_DONE, code, st));
        link_phase = PH_IDLE;
        rx_count   = 16'd0;
        idle_ms    = 16'd0;
    endtask

    task automatic predict_link_words(input in_item_t w);
        logic [15:0] plen;
        logic [15:0] data_cap;
        out_item_t   tail;
        step_words.delete();
        plen = 16'(w.param_count) + 16'd3;
        case (w.req_type)
            REQ_START: begin
                step_words.push_back(make_word(KIND_TX, SYNC_HI, ST_OK));
                step_words.push_back(make_word(KIND_TX, SYNC_LO, ST_OK));
                step_words.push_back(make_word(KIND_TX, dev_addr[31:24], ST_OK));
                step_words.push_back(make_word(KIND_TX, dev_addr[23:16], ST_OK));
                step_words.push_back(make_word(KIND_TX, dev_addr[15:8], ST_OK));
                step_words.push_back(make_word(KIND_TX, dev_addr[7:0], ST_OK));
                step_words.push_back(make_word(KIND_TX, PID_COMMAND, ST_OK));
                step_words.push_back(make_word(KIND_TX, plen[15:8], ST_OK));
                step_words.push_back(make_word(KIND_TX, plen[7:0], ST_OK));
                step_words.push_back(make_word(KIND_TX, w.in_byte, ST_OK));
                frame_sum  = 16'd1 + 16'(plen[15:8]) + 16'(plen[7:0]) + 16'(w.in_byte);
                params_due = w.param_count;
                resp_len   = 16'd0;
                confirm    = 8'd0;
                if (w.param_count == 8'd0) begin
                    close_frame();
                end else begin
                    link_phase = PH_PARAMS;
                    rx_count   = 16'd0;
                    idle_ms    = 16'd0;
                    hdr_good   = 1'b1;
                end
            end
            REQ_PARAM: begin
                if (link_phase == PH_PARAMS) begin
                    step_words.push_back(make_word(KIND_TX, w.in_byte, ST_OK));
                    frame_sum  = frame_sum + 16'(w.in_byte);
                    params_due = params_due - 8'd1;
                    if (params_due == 8'd0)
                        close_frame();
                end
            end
            REQ_RX: begin
                case (link_phase)
                    PH_HEADER: begin
                        idle_ms = 16'd0;
                        if (rx_count == 16'd0 && w.in_byte != SYNC_HI)
                            hdr_good = 1'b0;
                        if (rx_count == 16'd1 && w.in_byte != SYNC_LO)
                            hdr_good = 1'b0;
                        if (rx_count == 16'd7)
                            resp_len[15:8] = w.in_byte;
                        if (rx_count == 16'd8)
                            resp_len[7:0] = w.in_byte;
                        rx_count = rx_count + 16'd1;
                        if (rx_count >= 16'd9) begin
                            if (!hdr_good) begin
                                end_exchange(CODE_BADHDR, ST_BADHDR);
                            end else begin
                                link_phase = PH_CONFIRM;
                                rx_count   = 16'd0;
                            end
                        end
                    end
                    PH_CONFIRM: begin
                        idle_ms  = 16'd0;
                        confirm  = w.in_byte;
                        rx_count = 16'd0;
                        if (resp_len <= 16'd1)
                            end_exchange(confirm, ST_OK);
                        else
                            link_phase = PH_BODY;
                    end
                    PH_BODY: begin
                        idle_ms = 16'd0;
                        // data words stop at the cap, the rest of the body is drained
                        if (resp_len < 16'd3)
                            data_cap = 16'd0;
                        else if (resp_len - 16'd3 > 16'(MAX_REPLY_BYTES))
                            data_cap = 16'(MAX_REPLY_BYTES);
                        else
                            data_cap = resp_len - 16'd3;
                        if (rx_count < data_cap)
                            step_words.push_back(make_word(KIND_DATA, w.in_byte, ST_OK));
                        rx_count = rx_count + 16'd1;
                        if (rx_count >= resp_len - 16'd1)
                            end_exchange(confirm, ST_OK);
                    end
                    default: ;
                endcase
            end
            default: begin
                if (link_phase == PH_HEADER || link_phase == PH_CONFIRM ||
                    link_phase == PH_BODY) begin
                    idle_ms = idle_ms + 16'd1;
                    if (idle_ms == 16'd0 || idle_ms >= tmo_ticks) begin
                        if (link_phase == PH_BODY)
                            end_exchange(confirm, ST_OK);
                        else
                            end_exchange(CODE_NOREPLY, ST_NOREPLY);
                    end
                end
            end
        endcase
        if (step_words.size() > 0) begin
            tail = step_words.pop_back();
            tail.last = 1'b1;
            step_words.push_back(tail);
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            err_count  = 0;
            tmo_ticks  = TIMEOUT_RESET;
            dev_addr   = ADDR_RESET;
            link_phase = PH_IDLE;
            rx_count   = 16'd0;
            frame_sum  = 16'd0;
            params_due = 8'd0;
            resp_len   = 16'd0;
            confirm    = 8'd0;
            hdr_good   = 1'b1;
            idle_ms    = 16'd0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing expected", m_item.out_byte, 8'h00);
                end else begin
                    want = expected_words.pop_front();
                    if (m_item.out_kind !== want.out_kind)
                        report_mismatch("out_kind", 8'(m_item.out_kind), 8'(want.out_kind));
                    if (m_item.out_byte !== want.out_byte)
                        report_mismatch("out_byte", m_item.out_byte, want.out_byte);
                    if (m_item.status !== want.status)
                        report_mismatch("status", 8'(m_item.status), 8'(want.status));
                    if (m_item.last !== want.last)
                        report_mismatch("last", 8'(m_item.last), 8'(want.last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_BYTE_TIMEOUT)
                    tmo_ticks = cfg_data[15:0];
                else
                    dev_addr = cfg_data;
            end
            if (s_valid && s_ready)
                predict_link_words(s_item);
        end
        words_due = expected_words.size();
    end

endmodule

>>> dv/fingerprint_packet_link_tb.sv
`timescale 1ns / 1ps

module fingerprint_packet_link_tb;
    import fpl_pkg::*;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_item    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b1;
    out_item_t   m_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_BYTE_TIMEOUT;
    logic [31:0] cfg_data  = '0;

    int err_count;
    int words_due;

    bit          no_idle     = 1'b0;
    int unsigned sink_hold   = 0;
    int unsigned sent_words  = 0;
    logic [15:0] cur_timeout = TIMEOUT_RESET;

    fingerprint_packet_link u_dut (.*);

    fpl_link_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver back-pressure in random bursts
    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 9);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // entered and left at a falling edge; valid stays up for a following word
    task automatic send_word(input req_t kind, input logic [7:0] b, input logic [7:0] cnt);
        int unsigned gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{req_type: kind, in_byte: b, param_count: cnt};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent_words++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic program_link(input logic [15:0] tmo, input logic [31:0] addr);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BYTE_TIMEOUT;
        cfg_data  <= 32'(tmo);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= CFG_DEVICE_ADDR;
        cfg_data  <= addr;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid   <= 1'b0;
        cur_timeout = tmo;
    endtask

    // one command frame and a reply that is good, spoilt, cut short or abandoned
    task automatic run_exchange();
        int unsigned n_par;
        int unsigned flavour;
        int unsigned total;
        int unsigned spoil;
        int unsigned i;
        logic [15:0] len;
        logic [7:0]  hdr [9];
        logic [7:0]  b;
        if ($urandom_range(0, 5) == 0) begin
            // stray word of any kind, left out of the count
            send_word(req_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            sent_words--;
        end
        n_par = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        send_word(REQ_START, 8'($urandom), 8'(n_par));
        for (i = 0; i < n_par; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word($urandom_range(0, 1) ? REQ_RX : REQ_TICK, 8'($urandom), 8'($urandom));
            send_word(REQ_PARAM, 8'($urandom), 8'($urandom));
        end

        flavour = $urandom_range(0, 9);
        if (flavour < 6)
            len = 16'($urandom_range(0, 8));
        else if (flavour < 8)
            len = 16'($urandom_range(9, 40));
        else
            len = 16'($urandom);
        hdr[0] = SYNC_HI;
        hdr[1] = SYNC_LO;
        for (i = 2; i < 6; i++)
            hdr[i] = 8'($urandom);
        hdr[6] = 8'h07;
        hdr[7] = len[15:8];
        hdr[8] = len[7:0];
        total = 10 + ((len > 16'd1) ? 32'(len) - 1 : 0);
        if (flavour == 9) begin
            spoil = $urandom_range(0, 1);
            hdr[spoil] = hdr[spoil] ^ 8'(1 << $urandom_range(0, 7));
            total = 9;
        end else if (flavour == 8) begin
            total = $urandom_range(0, (total > 25) ? 24 : total - 1);
        end

        for (i = 0; i < total; i++) begin
            b = (i < 9) ? hdr[i] : 8'($urandom);
            if ($urandom_range(0, 11) == 0)
                send_word(REQ_TICK, 8'($urandom), 8'($urandom));
            send_word(REQ_RX, b, 8'($urandom));
        end
        // let a cut-short reply run out of time where that is quick
        if (flavour == 8 && cur_timeout <= 16'd20)
            repeat (int'(cur_timeout) + 1) send_word(REQ_TICK, 8'($urandom), 8'($urandom));
    endtask

    initial begin : stimulus
        logic [7:0] empty_reply [10] = '{8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                         8'h07, 8'h00, 8'h00, 8'h00};
        int unsigned stage;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // nothing in flight: these are all dropped
        send_word(REQ_TICK, 8'h00, 8'h00);
        send_word(REQ_RX, SYNC_HI, 8'hFF);
        send_word(REQ_PARAM, 8'hFF, 8'h00);
        // longest parameter list, cut off by a fresh start
        send_word(REQ_START, 8'hFF, 8'hFF);
        send_word(REQ_START, 8'h00, 8'h00);
        // zero-length reply ends on the confirmation word
        foreach (empty_reply[i])
            send_word(REQ_RX, empty_reply[i], 8'h00);
        send_word(REQ_START, 8'h5A, 8'h01);
        send_word(REQ_PARAM, 8'hA5, 8'h00);

        for (stage = 0; stage < 4; stage++) begin
            settle();
            case (stage)
                0: program_link(16'd1, 32'h0000_0000);
                1: program_link(16'd0, $urandom);
                2: program_link(16'hFFFF, 32'hFFFF_FFFF);
                default: begin
                    program_link(16'($urandom_range(2, 12)), $urandom);
                    no_idle = 1'b1;
                end
            endcase
            sent_words = 0;
            while (sent_words < 28)
                run_exchange();
        end
        settle();

        if (err_count == 0 && words_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
design/fpl_pkg.sv
design/fpl_front.sv
design/fpl_queue.sv
design/fpl_back.sv
design/fingerprint_packet_link.sv
dv/fpl_link_checker.sv
dv/fingerprint_packet_link_tb.sv
